// ===== sv/apu_pkg.sv =====
package apu_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 34;

    localparam logic [31:0] LR_RESET    = 32'd4294967;
    localparam logic [31:0] BETA1_RESET = 32'd3865470566;
    localparam logic [31:0] BETA2_RESET = 32'd4290672329;
    localparam logic [31:0] EPS_RESET   = 32'd43;

    localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
    localparam logic [33:0] STEP_MAX = 34'h2_0000_0000;

    typedef enum logic [2:0] {
        REG_LR    = 3'd0,
        REG_BETA1 = 3'd1,
        REG_BETA2 = 3'd2,
        REG_EPS   = 3'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] lr;
        logic [31:0] beta1;
        logic [31:0] beta2;
        logic [31:0] eps;
    } cfg_t;

    typedef struct packed {
        logic        upd;
        logic [31:0] p;
        logic [31:0] m;
        logic [31:0] v;
        logic [32:0] q1;
        logic        s2_full;
    } ctx_t;

    function automatic logic [31:0] sat_s32(input logic signed [39:0] x);
        logic [31:0] r;
        if (x > 40'sd2147483647)
        begin
            r = 32'h7fff_ffff;
        end
        else if (x < -40'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_u32(input logic signed [39:0] x);
        logic [31:0] r;
        if (x < 40'sd0)
        begin
            r = 32'd0;
        end
        else if (x > 40'sd4294967295)
        begin
            r = 32'hffff_ffff;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/apu_moment.sv =====
module apu_moment
    import apu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] p_in,
    input  logic [31:0] m_in,
    input  logic [31:0] v_in,
    input  logic [31:0] g_in,
    input  logic        upd_in,
    input  logic [32:0] q1_in,
    input  logic [32:0] q2_in,
    input  cfg_t        cfg,
    output logic        out_valid,
    output ctx_t        ctx_out,
    output logic [63:0] xa,
    output logic [63:0] xb
);

    logic [32:0] c1, c2;
    assign c1 = ONE_Q32 - {1'b0, cfg.beta1};
    assign c2 = ONE_Q32 - {1'b0, cfg.beta2};

    // stage 1: differences and gradient square
    logic signed [32:0] d1_next;
    logic [31:0] gmag;
    logic [32:0] mag1_next;
    logic [63:0] gsq1_next;
    logic        vld1_reg, upd1_reg, neg1_reg;
    logic [31:0] p1_reg, m1_reg, v1_reg;
    logic [32:0] q11_reg, q21_reg, mag1_reg;
    logic [63:0] gsq1_reg;

    assign d1_next   = $signed({g_in[31], g_in}) - $signed({m_in[31], m_in});
    assign gmag      = g_in[31] ? (32'd0 - g_in) : g_in;
    assign mag1_next = d1_next[32] ? (33'd0 - d1_next) : d1_next;
    assign gsq1_next = {32'd0, gmag} * {32'd0, gmag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= p_in;
            m1_reg   <= m_in;
            v1_reg   <= v_in;
            upd1_reg <= upd_in;
            q11_reg  <= q1_in;
            q21_reg  <= q2_in;
            neg1_reg <= d1_next[32];
            mag1_reg <= mag1_next;
            gsq1_reg <= gsq1_next;
        end
    end

    // stage 2: first moment product, second moment difference
    logic [65:0] prod1_next;
    logic [34:0] gg;
    logic signed [35:0] d2_next;
    logic [35:0] mag2_next;
    logic        vld2_reg, upd2_reg, neg1b_reg, neg2_reg;
    logic [31:0] p2_reg, m2_reg, v2_reg;
    logic [32:0] q12_reg, q22_reg;
    logic [65:0] prod1_reg;
    logic [35:0] mag2_reg;

    assign prod1_next = {33'd0, mag1_reg} * {33'd0, c1};
    assign gg         = 35'((gsq1_reg + 64'd134217728) >> 28);
    assign d2_next    = $signed({1'b0, gg}) - $signed({4'd0, v1_reg});
    assign mag2_next  = d2_next[35] ? (36'd0 - d2_next) : d2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg    <= p1_reg;
            m2_reg    <= m1_reg;
            v2_reg    <= v1_reg;
            upd2_reg  <= upd1_reg;
            q12_reg   <= q11_reg;
            q22_reg   <= q21_reg;
            neg1b_reg <= neg1_reg;
            prod1_reg <= prod1_next;
            neg2_reg  <= d2_next[35];
            mag2_reg  <= mag2_next;
        end
    end

    // stage 3: new first moment, second moment product
    logic [33:0] r1;
    logic signed [39:0] mw;
    logic [68:0] prod2_next;
    logic        vld3_reg, upd3_reg, neg2b_reg;
    logic [31:0] p3_reg, m3_reg, v3_reg, mn3_reg;
    logic [32:0] q13_reg, q23_reg;
    logic [68:0] prod2_reg;

    assign r1 = 34'((prod1_reg + 66'h8000_0000) >> 32);
    assign mw = neg1b_reg ? ($signed({{8{m2_reg[31]}}, m2_reg}) - $signed({6'd0, r1}))
                          : ($signed({{8{m2_reg[31]}}, m2_reg}) + $signed({6'd0, r1}));
    assign prod2_next = {33'd0, mag2_reg} * {36'd0, c2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_reg    <= p2_reg;
            m3_reg    <= m2_reg;
            v3_reg    <= v2_reg;
            upd3_reg  <= upd2_reg;
            q13_reg   <= q12_reg;
            q23_reg   <= q22_reg;
            mn3_reg   <= sat_s32(mw);
            neg2b_reg <= neg2_reg;
            prod2_reg <= prod2_next;
        end
    end

    // stage 4: new second moment, root operands
    logic [36:0] r2;
    logic signed [39:0] vw;
    logic [31:0] vn;
    ctx_t        ctx_next;
    logic        vld4_reg;
    ctx_t        ctx4_reg;
    logic [63:0] xa4_reg, xb4_reg;

    assign r2 = 37'((prod2_reg + 69'h8000_0000) >> 32);
    assign vw = neg2b_reg ? ($signed({8'd0, v3_reg}) - $signed({3'd0, r2}))
                          : ($signed({8'd0, v3_reg}) + $signed({3'd0, r2}));
    assign vn = sat_u32(vw);

    always_comb
    begin
        ctx_next.upd     = upd3_reg;
        ctx_next.p       = p3_reg;
        ctx_next.m       = upd3_reg ? mn3_reg : m3_reg;
        ctx_next.v       = upd3_reg ? vn : v3_reg;
        ctx_next.q1      = q13_reg;
        ctx_next.s2_full = q23_reg[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx4_reg <= ctx_next;
            xa4_reg  <= q23_reg[32] ? 64'd0 : {q23_reg[31:0], 32'd0};
            xb4_reg  <= {4'd0, vn, 28'd0};
        end
    end

    assign out_valid = vld4_reg;
    assign ctx_out   = ctx4_reg;
    assign xa        = xa4_reg;
    assign xb        = xb4_reg;

endmodule

// ===== sv/apu_sqrt.sv =====
module apu_sqrt
    import apu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  ctx_t        ctx_in,
    input  logic [63:0] xa,
    input  logic [63:0] xb,
    output logic        out_valid,
    output ctx_t        ctx_out,
    output logic [31:0] root_a,
    output logic [31:0] root_b
);

    // one result bit per stage, both lanes side by side
    function automatic logic [34:0] sqrt_step(input logic [33:0] rem, input logic [31:0] root,
                                              input logic [1:0] two);
        logic [35:0] sh;
        logic [35:0] tr;
        logic [34:0] r;
        sh = {rem, two};
        tr = {2'd0, root, 2'b01};
        if (sh >= tr)
        begin
            r = {1'b1, 34'(sh - tr)};
        end
        else
        begin
            r = {1'b0, sh[33:0]};
        end
        return r;
    endfunction

    logic        vld_reg   [SQRT_STAGES];
    ctx_t        ctx_reg   [SQRT_STAGES];
    logic [63:0] xa_reg    [SQRT_STAGES];
    logic [63:0] xb_reg    [SQRT_STAGES];
    logic [33:0] rema_reg  [SQRT_STAGES];
    logic [33:0] remb_reg  [SQRT_STAGES];
    logic [31:0] roota_reg [SQRT_STAGES];
    logic [31:0] rootb_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_st
        logic        v_i;
        ctx_t        c_i;
        logic [63:0] xa_i, xb_i;
        logic [33:0] ra_i, rb_i;
        logic [31:0] oa_i, ob_i;
        logic [34:0] sa_next, sb_next;

        if (k == 0)
        begin : g_first
            assign v_i  = in_valid;
            assign c_i  = ctx_in;
            assign xa_i = xa;
            assign xb_i = xb;
            assign ra_i = '0;
            assign rb_i = '0;
            assign oa_i = '0;
            assign ob_i = '0;
        end
        else
        begin : g_rest
            assign v_i  = vld_reg[k-1];
            assign c_i  = ctx_reg[k-1];
            assign xa_i = xa_reg[k-1];
            assign xb_i = xb_reg[k-1];
            assign ra_i = rema_reg[k-1];
            assign rb_i = remb_reg[k-1];
            assign oa_i = roota_reg[k-1];
            assign ob_i = rootb_reg[k-1];
        end

        assign sa_next = sqrt_step(ra_i, oa_i, xa_i[63:62]);
        assign sb_next = sqrt_step(rb_i, ob_i, xb_i[63:62]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[k]   <= c_i;
                xa_reg[k]    <= {xa_i[61:0], 2'b00};
                xb_reg[k]    <= {xb_i[61:0], 2'b00};
                rema_reg[k]  <= sa_next[33:0];
                remb_reg[k]  <= sb_next[33:0];
                roota_reg[k] <= {oa_i[30:0], sa_next[34]};
                rootb_reg[k] <= {ob_i[30:0], sb_next[34]};
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign ctx_out   = ctx_reg[SQRT_STAGES-1];
    assign root_a    = roota_reg[SQRT_STAGES-1];
    assign root_b    = rootb_reg[SQRT_STAGES-1];

endmodule

// ===== sv/apu_scale.sv =====
module apu_scale
    import apu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  ctx_t        ctx_in,
    input  logic [31:0] s2_root,
    input  logic [31:0] sv,
    input  cfg_t        cfg,
    output logic        out_valid,
    output ctx_t        ctx_out,
    output logic [34:0] dq,
    output logic [63:0] num,
    output logic        ovf
);

    // stage 1: bias correction products
    logic [32:0] s2;
    logic        vld1_reg;
    ctx_t        ctx1_reg;
    logic [64:0] es1_reg, ls1_reg;
    logic [29:0] sv1_reg;

    assign s2 = ctx_in.s2_full ? ONE_Q32 : {1'b0, s2_root};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx1_reg <= ctx_in;
            es1_reg  <= {33'd0, cfg.eps} * {32'd0, s2};
            ls1_reg  <= {33'd0, cfg.lr} * {32'd0, s2};
            sv1_reg  <= sv[29:0];
        end
    end

    // stage 2: denominator and corrected rate
    logic        vld2_reg;
    ctx_t        ctx2_reg;
    logic [34:0] den2_reg;
    logic [32:0] lre2_reg;
    logic [34:0] den_next;

    assign den_next = 35'((es1_reg + 65'h8000_0000) >> 32) + {1'b0, sv1_reg, 4'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx2_reg <= ctx1_reg;
            den2_reg <= den_next;
            lre2_reg <= 33'((ls1_reg + 65'h8000_0000) >> 32);
        end
    end

    // stage 3: scaled denominator, numerator product
    logic [31:0] mmag;
    logic        vld3_reg;
    ctx_t        ctx3_reg;
    logic [67:0] dqp3_reg;
    logic [64:0] y3_reg;

    assign mmag = ctx2_reg.m[31] ? (32'd0 - ctx2_reg.m) : ctx2_reg.m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx3_reg <= ctx2_reg;
            dqp3_reg <= {33'd0, den2_reg} * {35'd0, ctx2_reg.q1};
            y3_reg   <= {32'd0, lre2_reg} * {33'd0, mmag};
        end
    end

    // stage 4: rounded denominator, zero guarded
    logic [34:0] dq_next;
    logic        vld4_reg;
    ctx_t        ctx4_reg;
    logic [34:0] dq4_reg;
    logic [63:0] y4_reg;

    assign dq_next = 35'((dqp3_reg + 68'h8000_0000) >> 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx4_reg <= ctx3_reg;
            dq4_reg  <= (dq_next == 35'd0) ? 35'd1 : dq_next;
            y4_reg   <= y3_reg[63:0];
        end
    end

    // stage 5: rounding bias and quotient range check
    logic [63:0] num_next;
    logic        vld5_reg, ovf5_reg;
    ctx_t        ctx5_reg;
    logic [34:0] dq5_reg;
    logic [63:0] num5_reg;

    assign num_next = y4_reg + {30'd0, dq4_reg[34:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld5_reg <= 1'b0;
        end
        else if (en)
        begin
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx5_reg <= ctx4_reg;
            dq5_reg  <= dq4_reg;
            num5_reg <= num_next;
            ovf5_reg <= {5'd0, num_next[63:34]} >= dq4_reg;
        end
    end

    assign out_valid = vld5_reg;
    assign ctx_out   = ctx5_reg;
    assign dq        = dq5_reg;
    assign num       = num5_reg;
    assign ovf       = ovf5_reg;

endmodule

// ===== sv/apu_div.sv =====
module apu_div
    import apu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  ctx_t        ctx_in,
    input  logic [34:0] dq,
    input  logic [63:0] num,
    input  logic        ovf,
    output logic        out_valid,
    output logic [31:0] weight_out,
    output logic [31:0] first_moment_out,
    output logic [31:0] second_moment_out
);

    logic        vld_reg [DIV_STAGES];
    ctx_t        ctx_reg [DIV_STAGES];
    logic [34:0] rem_reg [DIV_STAGES];
    logic [33:0] nlo_reg [DIV_STAGES];
    logic [33:0] q_reg   [DIV_STAGES];
    logic [34:0] dq_reg  [DIV_STAGES];
    logic        ovf_reg [DIV_STAGES];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_st
        logic        v_i, o_i;
        ctx_t        c_i;
        logic [34:0] r_i, d_i;
        logic [33:0] n_i, q_i;
        logic [35:0] sh;
        logic        qb;

        if (k == 0)
        begin : g_first
            assign v_i = in_valid;
            assign c_i = ctx_in;
            assign r_i = ovf ? 35'd0 : {5'd0, num[63:34]};
            assign n_i = num[33:0];
            assign q_i = '0;
            assign d_i = dq;
            assign o_i = ovf;
        end
        else
        begin : g_rest
            assign v_i = vld_reg[k-1];
            assign c_i = ctx_reg[k-1];
            assign r_i = rem_reg[k-1];
            assign n_i = nlo_reg[k-1];
            assign q_i = q_reg[k-1];
            assign d_i = dq_reg[k-1];
            assign o_i = ovf_reg[k-1];
        end

        assign sh = {r_i, n_i[33]};
        assign qb = sh >= {1'b0, d_i};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[k] <= c_i;
                rem_reg[k] <= qb ? 35'(sh - {1'b0, d_i}) : sh[34:0];
                nlo_reg[k] <= {n_i[32:0], 1'b0};
                q_reg[k]   <= {q_i[32:0], qb};
                dq_reg[k]  <= d_i;
                ovf_reg[k] <= o_i;
            end
        end
    end

    // output word: limited step applied against the sign of the moment when the update flag is set
    ctx_t        cl;
    logic [33:0] ql;
    logic [33:0] step;
    logic signed [39:0] pw;
    logic [31:0] p_next;
    logic        out_valid_reg;
    logic [31:0] p_reg, m_reg, v_reg;

    assign cl   = ctx_reg[DIV_STAGES-1];
    assign ql   = q_reg[DIV_STAGES-1];
    assign step = (ovf_reg[DIV_STAGES-1] || (ql > STEP_MAX)) ? STEP_MAX : ql;
    assign pw   = cl.m[31] ? ($signed({{8{cl.p[31]}}, cl.p}) + $signed({6'd0, step}))
                           : ($signed({{8{cl.p[31]}}, cl.p}) - $signed({6'd0, step}));
    assign p_next = cl.upd ? sat_s32(pw) : cl.p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
            m_reg <= cl.m;
            v_reg <= cl.v;
        end
    end

    assign out_valid         = out_valid_reg;
    assign weight_out        = p_reg;
    assign first_moment_out  = m_reg;
    assign second_moment_out = v_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DIV_STAGES-1] && !ovf_reg[DIV_STAGES-1])
            |-> (rem_reg[DIV_STAGES-1] < dq_reg[DIV_STAGES-1]))
        else $error("division remainder not below divisor");

endmodule

// ===== sv/adam_parameter_update.sv =====
// path from an accepted input word to its result word
// (4 moment stages, 32 root stages, 5 scaling stages, 34 divide stages, 1 output register)
// throughput: one word per cycle; a stalled output freezes every stage at once
// reset: stage valid bits clear, configuration registers take their defaults, beta powers take the beta defaults
module adam_parameter_update
    import apu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // weight_in, first_moment_in, second_moment_in, gradient
    input  logic         s_tuser,   // update_valid
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // weight_out, first_moment_out, second_moment_out
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic        en, acc;
    cfg_t        cfg_reg;
    logic [31:0] beta1_power_reg, beta2_power_reg;
    logic [31:0] beta1_power_next, beta2_power_next;
    logic [63:0] bp1_prod, bp2_prod;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign acc       = s_tvalid && en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lr    <= LR_RESET;
            cfg_reg.beta1 <= BETA1_RESET;
            cfg_reg.beta2 <= BETA2_RESET;
            cfg_reg.eps   <= EPS_RESET;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_LR:    cfg_reg.lr    <= cfg_data;
                REG_BETA1: cfg_reg.beta1 <= cfg_data;
                REG_BETA2: cfg_reg.beta2 <= cfg_data;
                REG_EPS:   cfg_reg.eps   <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign bp1_prod         = {32'd0, beta1_power_reg} * {32'd0, cfg_reg.beta1};
    assign bp2_prod         = {32'd0, beta2_power_reg} * {32'd0, cfg_reg.beta2};
    assign beta1_power_next = 32'((bp1_prod + 64'h8000_0000) >> 32);
    assign beta2_power_next = 32'((bp2_prod + 64'h8000_0000) >> 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta1_power_reg <= BETA1_RESET;
            beta2_power_reg <= BETA2_RESET;
        end
        else if (acc && s_tuser && s_tlast)
        begin
            beta1_power_reg <= beta1_power_next;
            beta2_power_reg <= beta2_power_next;
        end
    end

    logic        mo_valid, sq_valid, sc_valid;
    ctx_t        mo_ctx, sq_ctx, sc_ctx;
    logic [63:0] xa, xb;
    logic [31:0] root_a, root_b;
    logic [34:0] dq;
    logic [63:0] num;
    logic        ovf;
    logic [31:0] weight_out, first_moment_out, second_moment_out;

    apu_moment u_moment (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .p_in      (s_tdata[31:0]),
        .m_in      (s_tdata[63:32]),
        .v_in      (s_tdata[95:64]),
        .g_in      (s_tdata[127:96]),
        .upd_in    (s_tuser),
        .q1_in     (ONE_Q32 - {1'b0, beta1_power_reg}),
        .q2_in     (ONE_Q32 - {1'b0, beta2_power_reg}),
        .cfg       (cfg_reg),
        .out_valid (mo_valid),
        .ctx_out   (mo_ctx),
        .xa        (xa),
        .xb        (xb)
    );

    apu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mo_valid),
        .ctx_in    (mo_ctx),
        .xa        (xa),
        .xb        (xb),
        .out_valid (sq_valid),
        .ctx_out   (sq_ctx),
        .root_a    (root_a),
        .root_b    (root_b)
    );

    apu_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .ctx_in    (sq_ctx),
        .s2_root   (root_a),
        .sv        (root_b),
        .cfg       (cfg_reg),
        .out_valid (sc_valid),
        .ctx_out   (sc_ctx),
        .dq        (dq),
        .num       (num),
        .ovf       (ovf)
    );

    apu_div u_div (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (sc_valid),
        .ctx_in            (sc_ctx),
        .dq                (dq),
        .num               (num),
        .ovf               (ovf),
        .out_valid         (m_tvalid),
        .weight_out        (weight_out),
        .first_moment_out  (first_moment_out),
        .second_moment_out (second_moment_out)
    );

    assign m_tdata = {second_moment_out, first_moment_out, weight_out};

    assert property (@(posedge clk) disable iff (!rst_n)
        !(acc && s_tuser && s_tlast) |=> ($stable(beta1_power_reg) && $stable(beta2_power_reg)))
        else $error("beta powers moved without a step end word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && (cfg_index != REG_BETA1) && (cfg_index != REG_BETA2)) |=> $stable(cfg_reg.beta1))
        else $error("beta1 changed by a write to another register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!en) |=> $stable(m_tdata))
        else $error("result word changed during a stall");

endmodule

// ===== tb/tb_adam_parameter_update.sv =====
module tb_adam_parameter_update
    import apu_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 700;
    localparam int N_PHASES = 6;
    localparam int LONG_HOLD = 400;
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;

    class adam_scoreboard;
        logic [31:0] lr;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] eps;
        logic [31:0] b1_pow;
        logic [31:0] b2_pow;
        logic [95:0] pending[$];

        function new();
            lr = LR_RESET;
            b1 = BETA1_RESET;
            b2 = BETA2_RESET;
            eps = EPS_RESET;
            b1_pow = BETA1_RESET;
            b2_pow = BETA2_RESET;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_LR:    lr = d;
                REG_BETA1: b1 = d;
                REG_BETA2: b2 = d;
                REG_EPS:   eps = d;
                default: ;
            endcase
        endfunction

        // a*f/2^32 rounded to nearest
        function logic [63:0] scale_q32(logic [63:0] a, logic [63:0] f);
            logic [127:0] t;
            t = {64'd0, a} * {64'd0, f} + 128'h8000_0000;
            return t[95:32];
        endfunction

        function longint scale_q32_signed(longint d, logic [63:0] f);
            logic [63:0] mag;
            logic [63:0] r;
            mag = (d < 0) ? 64'(-d) : 64'(d);
            r = scale_q32(mag, f);
            return (d < 0) ? -longint'(r) : longint'(r);
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint clamp_s32(longint x);
            if (x > 64'sd2147483647)
                return 64'sd2147483647;
            if (x < -64'sd2147483648)
                return -64'sd2147483648;
            return x;
        endfunction

        function void note(logic [127:0] d, bit upd, bit last);
            longint p;
            longint m;
            longint g;
            longint mn;
            longint vs;
            longint pn;
            logic [63:0] v;
            logic [63:0] gm;
            logic [63:0] gg;
            logic [63:0] vn;
            logic [63:0] q1;
            logic [63:0] q2;
            logic [63:0] s2;
            logic [63:0] sv;
            logic [63:0] den;
            logic [63:0] dq;
            logic [63:0] lre;
            logic [63:0] mmag;
            logic [63:0] step;
            p = longint'($signed(d[31:0]));
            m = longint'($signed(d[63:32]));
            v = {32'd0, d[95:64]};
            g = longint'($signed(d[127:96]));
            if (!upd)
            begin
                pending.push_back(d[95:0]);
                return;
            end
            mn = clamp_s32(m + scale_q32_signed(g - m, Q32_ONE - b1));
            gm = (g < 0) ? 64'(-g) : 64'(g);
            gg = (gm * gm + (64'd1 << 27)) >> 28;
            vs = longint'(v) + scale_q32_signed(longint'(gg) - longint'(v), Q32_ONE - b2);
            if (vs < 0)
                vn = 0;
            else if (vs > 64'sh0_FFFF_FFFF)
                vn = 64'hFFFF_FFFF;
            else
                vn = 64'(vs);
            q1 = Q32_ONE - b1_pow;
            q2 = Q32_ONE - b2_pow;
            s2 = (q2 >= Q32_ONE) ? Q32_ONE : int_sqrt(q2 << 32);
            sv = int_sqrt(vn << 28);
            den = scale_q32({32'd0, eps}, s2) + (sv << 4);
            dq = scale_q32(den, q1);
            if (dq == 0)
                dq = 1;
            lre = scale_q32({32'd0, lr}, s2);
            mmag = (mn < 0) ? 64'(-mn) : 64'(mn);
            step = (lre * mmag + (dq >> 1)) / dq;
            if (step > (64'd1 << 33))
                step = 64'd1 << 33;
            pn = clamp_s32((mn < 0) ? p + longint'(step) : p - longint'(step));
            pending.push_back({vn[31:0], mn[31:0], pn[31:0]});
            if (last)
            begin
                b1_pow = 32'(scale_q32({32'd0, b1_pow}, {32'd0, b1}));
                b2_pow = 32'(scale_q32({32'd0, b2_pow}, {32'd0, b2}));
            end
        endfunction

        function bit take(output logic [95:0] e);
            if (pending.size() == 0)
                return 0;
            e = pending.pop_front();
            return 1;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [127:0] s_tdata = '0;
    logic s_tuser = 0;
    logic s_tlast = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [95:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    adam_scoreboard sb = new();
    int errors = 0;
    int cycles = 0;
    int words_in = 0;
    int words_out = 0;
    bit no_idle = 0;
    bit hold_req = 0;

    adam_parameter_update uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL adam_parameter_update");
            $finish;
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch word %0d %s: got %h expected %h", words_out, what, got, want);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, d);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send(logic [31:0] p, logic [31:0] m, logic [31:0] v, logic [31:0] g,
                        bit upd, bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {g, v, m, p};
        s_tuser <= upd;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        sb.note({g, v, m, p}, upd, last);
        words_in++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_field();
        logic [31:0] x;
        case ($urandom_range(0, 5))
            0: x = $urandom;
            1: x = $urandom >> $urandom_range(0, 31);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: x = 32'h7FFF_FFFF;
                    1: x = 32'h8000_0000;
                    2: x = 32'hFFFF_FFFF;
                    default: x = 32'h0;
                endcase
            end
            default: x = $urandom_range(0, 32'h0FFF_FFFF) >> $urandom_range(0, 12);
        endcase
        if ($urandom_range(0, 1) && x != 32'h8000_0000)
            x = -x;
        return x;
    endfunction

    function automatic logic [31:0] rnd_cfg();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_FFFF - ($urandom >> $urandom_range(4, 31));
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls plus one long hold-off
    initial
    begin
        logic [95:0] want;
        int gap;
        forever
        begin
            gap = $urandom_range(0, 15);
            if (hold_req)
            begin
                m_tready <= 0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 0;
            end
            else if (!no_idle && gap > 0)
            begin
                m_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
            if (!sb.take(want))
            begin
                report("unexpected word", m_tdata[31:0], 32'h0);
            end
            else
            begin
                if (m_tdata[31:0] !== want[31:0])
                    report("weight_out", m_tdata[31:0], want[31:0]);
                if (m_tdata[63:32] !== want[63:32])
                    report("first_moment_out", m_tdata[63:32], want[63:32]);
                if (m_tdata[95:64] !== want[95:64])
                    report("second_moment_out", m_tdata[95:64], want[95:64]);
            end
            words_out++;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed words at reset settings
        send(32'h0, 32'h0, 32'h0, 32'h0, 1, 0);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 0);
        send(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000, 1, 0);
        send(32'h0, 32'h7FFF_FFFF, 32'h1000_0000, 32'h8000_0000, 1, 0);
        send(32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 0);
        send(32'hDEAD_BEEF, 32'hCAFE_F00D, 32'hFFFF_FFFF, 32'h8000_0000, 0, 1);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        send(32'h0100_0000, 32'h0010_0000, 32'h0001_0000, 32'h0020_0000, 1, 1);
        send(32'hF000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1, 0);
        send(32'h1000_0000, 32'h0800_0000, 32'h0200_0000, 32'hF800_0000, 1, 1);
        wait_idle();

        // zero denominator, ignored index, full step size
        set_reg(REG_EPS, 32'h0);
        set_reg(REG_LR, 32'hFFFF_FFFF);
        set_reg(REG_UNUSED, 32'h1234_5678);
        send(32'h0, 32'h0000_0100, 32'h0, 32'h0, 1, 0);
        send(32'h7FFF_0000, 32'h8000_0000, 32'h0, 32'h0, 1, 0);
        send(32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0, 1, 0);
        wait_idle();

        // beta powers driven to zero
        set_reg(REG_BETA1, 32'h0);
        set_reg(REG_BETA2, 32'h0);
        send(32'h0, 32'h0, 32'h0, 32'h0100_0000, 1, 1);
        send(32'h0, 32'h0200_0000, 32'h0400_0000, 32'h0100_0000, 1, 0);
        send(32'h4000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 1);
        send(32'h0, 32'h0, 32'h0, 32'h0, 1, 0);
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                set_reg(REG_LR, rnd_cfg());
                set_reg(REG_BETA1, rnd_cfg());
                set_reg(REG_BETA2, rnd_cfg());
                set_reg(REG_EPS, rnd_cfg());
                if ($urandom_range(0, 1))
                    set_reg(3'($urandom_range(4, 7)), $urandom);
            end
            no_idle = (ph == 2) || (ph == 4);
            if (ph == 2)
                hold_req = 1;
            for (int i = 0; i < N_RANDOM / N_PHASES; i++)
                send(rnd_field(), rnd_field(), rnd_field(), rnd_field(),
                     $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
            s_tvalid <= 0;
            @(posedge clk);
            wait_idle();
        end

        repeat (100) @(posedge clk);
        $display("covered %0d input words and %0d result words over %0d setting phases",
                 words_in, words_out, N_PHASES + 3);
        $display("included saturation, pass-through, zero denominator and a long output stall");
        if (errors == 0 && sb.pending.size() == 0)
            $display("PASS adam_parameter_update");
        else
            $display("FAIL adam_parameter_update");
        $finish;
    end

endmodule
